@@ hdl/vudf_pkg.sv @@
// ----------------------------------------------------------------------------
// vudf_pkg
// Types, constants and fold functions shared by the Vietnamese UTF-8
// diacritic fold block.
// ----------------------------------------------------------------------------
package vudf_pkg;

	// Maximum bytes one input byte can release: three held bytes plus itself
	localparam int unsigned JobBytes = 4;
	localparam int unsigned JobCntW  = $clog2(JobBytes + 1);
	localparam int unsigned JobIdxW  = $clog2(JobBytes);

	// Job queue between front and back
	localparam int unsigned QDepth = 4;
	localparam int unsigned QPtrW  = $clog2(QDepth);
	localparam int unsigned QCntW  = $clog2(QDepth + 1);

	// Held partial sequence
	localparam int unsigned HeldDepth = 3;

	// Lead-byte masks and patterns
	localparam logic [7:0] MaskLead2 = 8'hE0;
	localparam logic [7:0] PatLead2  = 8'hC0;
	localparam logic [7:0] MaskLead3 = 8'hF0;
	localparam logic [7:0] PatLead3  = 8'hE0;
	localparam logic [7:0] MaskLead4 = 8'hF8;
	localparam logic [7:0] PatLead4  = 8'hF0;
	localparam logic [7:0] MaskCont  = 8'hC0;
	localparam logic [7:0] PatCont   = 8'h80;
	localparam logic [7:0] LeadViet3 = 8'hE1;
	localparam logic [7:0] CaseShift = 8'd32;

	localparam logic [2:0] Len2 = 3'd2;
	localparam logic [2:0] Len3 = 3'd3;
	localparam logic [2:0] Len4 = 3'd4;

	localparam logic [7:0] ChA  = 8'h61;
	localparam logic [7:0] ChD  = 8'h64;
	localparam logic [7:0] ChE  = 8'h65;
	localparam logic [7:0] ChI  = 8'h69;
	localparam logic [7:0] ChO  = 8'h6F;
	localparam logic [7:0] ChU  = 8'h75;
	localparam logic [7:0] ChY  = 8'h79;
	localparam logic [7:0] ChUpA = 8'h41;
	localparam logic [7:0] ChUpZ = 8'h5A;
	localparam logic [7:0] NoLetter = 8'h00;

	typedef struct packed {
		logic [JobBytes-1:0][7:0] bytes;
		logic [JobCntW-1:0]       cnt;
		logic                     eot;
	} vudf_job_t;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & MaskCont) == PatCont;
	endfunction

	// Base letter of a two-byte code point (11 bits), or NoLetter
	function automatic logic [7:0] fold_two(input logic [10:0] cp);
		logic [10:0] lo;
		logic [7:0]  res;
		lo  = (cp >= 11'h0E0 && cp <= 11'h0FF) ? cp - 11'h020 : cp;
		res = NoLetter;
		if (lo >= 11'h0C0 && lo <= 11'h0C3) res = ChA;
		else if (lo >= 11'h0C8 && lo <= 11'h0CA) res = ChE;
		else if (lo >= 11'h0CC && lo <= 11'h0CD) res = ChI;
		else if (lo >= 11'h0D2 && lo <= 11'h0D5) res = ChO;
		else if (lo >= 11'h0D9 && lo <= 11'h0DA) res = ChU;
		else if (lo == 11'h0DD) res = ChY;
		else if (cp == 11'h102 || cp == 11'h103) res = ChA;
		else if (cp == 11'h128 || cp == 11'h129) res = ChI;
		else if (cp == 11'h168 || cp == 11'h169) res = ChU;
		else if (cp == 11'h1A0 || cp == 11'h1A1) res = ChO;
		else if (cp == 11'h1AF || cp == 11'h1B0) res = ChU;
		else if (cp == 11'h110 || cp == 11'h111) res = ChD;
		return res;
	endfunction

	// Base letter of a three-byte code point under lead E1 (low 12 bits)
	function automatic logic [7:0] fold_three(input logic [11:0] cp);
		logic [7:0] res;
		res = NoLetter;
		if (cp >= 12'hEA0 && cp <= 12'hEF9) begin
			if (cp <= 12'hEB7) res = ChA;
			else if (cp <= 12'hEC7) res = ChE;
			else if (cp <= 12'hECB) res = ChI;
			else if (cp <= 12'hEE3) res = ChO;
			else if (cp <= 12'hEF1) res = ChU;
			else res = ChY;
		end
		return res;
	endfunction

endpackage

@@ hdl/vudf_in_if.sv @@
// ----------------------------------------------------------------------------
// vudf_in_if
// Raw text channel: one UTF-8 byte per transfer with an end-of-text mark.
// ----------------------------------------------------------------------------
interface vudf_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_text;

	modport source (output valid, output in_byte, output end_of_text, input ready);
	modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

@@ hdl/vudf_out_if.sv @@
// ----------------------------------------------------------------------------
// vudf_out_if
// Folded text channel: one output byte per transfer with run and text marks.
// ----------------------------------------------------------------------------
interface vudf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       text_done;

	modport source (output valid, output out_byte, output run_last, output text_done,
		input ready);
	modport sink   (input valid, input out_byte, input run_last, input text_done,
		output ready);
endinterface

@@ hdl/vudf_front.sv @@
// ----------------------------------------------------------------------------
// vudf_front
// Accept raw bytes, track partial sequences and build a job per releasing byte.
// ----------------------------------------------------------------------------
module vudf_front (
	input  logic                clk,
	input  logic                arst_n,
	vudf_in_if.sink             raw,
	input  logic                q_full,
	output logic                push,
	output vudf_pkg::vudf_job_t job
);

	logic [7:0] held_q [vudf_pkg::HeldDepth];
	logic [1:0] held_cnt_q;
	logic [2:0] exp_len_q;

	logic [7:0] nxt_held [vudf_pkg::HeldDepth];
	logic [1:0] nxt_cnt;
	logic [2:0] nxt_len;
	logic [7:0] c;
	logic [7:0] letter;
	logic       accept;

	assign c         = raw.in_byte;
	assign raw.ready = !q_full;
	assign accept    = raw.valid && raw.ready;
	assign push      = accept && (job.cnt != '0);

	always_comb begin
		nxt_held = held_q;
		nxt_cnt  = held_cnt_q;
		nxt_len  = exp_len_q;
		letter   = vudf_pkg::NoLetter;
		job      = '0;
		if (held_cnt_q == 2'd0) begin
			if (!c[7]) begin
				job.bytes[0] = (c >= vudf_pkg::ChUpA && c <= vudf_pkg::ChUpZ) ?
					c + vudf_pkg::CaseShift : c;
				job.cnt = vudf_pkg::JobCntW'(1);
			end else if ((c & vudf_pkg::MaskLead2) == vudf_pkg::PatLead2) begin
				nxt_held[0] = c;
				nxt_cnt     = 2'd1;
				nxt_len     = vudf_pkg::Len2;
			end else if ((c & vudf_pkg::MaskLead3) == vudf_pkg::PatLead3) begin
				nxt_held[0] = c;
				nxt_cnt     = 2'd1;
				nxt_len     = vudf_pkg::Len3;
			end else if ((c & vudf_pkg::MaskLead4) == vudf_pkg::PatLead4) begin
				nxt_held[0] = c;
				nxt_cnt     = 2'd1;
				nxt_len     = vudf_pkg::Len4;
			end else begin
				job.bytes[0] = c;
				job.cnt      = vudf_pkg::JobCntW'(1);
			end
		end else if ({1'b0, held_cnt_q} + 3'd1 < exp_len_q) begin
			if (held_cnt_q != 2'd3)
				nxt_held[held_cnt_q] = c;
			nxt_cnt = held_cnt_q + 2'd1;
		end else begin
			if (exp_len_q == vudf_pkg::Len2 && vudf_pkg::is_cont(c))
				letter = vudf_pkg::fold_two({held_q[0][4:0], c[5:0]});
			else if (exp_len_q == vudf_pkg::Len3 && vudf_pkg::is_cont(held_q[1]) &&
				vudf_pkg::is_cont(c) && held_q[0] == vudf_pkg::LeadViet3)
				letter = vudf_pkg::fold_three({held_q[1][5:0], c[5:0]});
			if (letter != vudf_pkg::NoLetter) begin
				job.bytes[0] = letter;
				job.cnt      = vudf_pkg::JobCntW'(1);
			end else begin
				// The held run is always one short of the sequence length here
				job.bytes[0]          = held_q[0];
				job.bytes[1]          = held_q[1];
				job.bytes[2]          = held_q[2];
				job.bytes[held_cnt_q] = c;
				job.cnt               = vudf_pkg::JobCntW'(held_cnt_q) +
					vudf_pkg::JobCntW'(1);
			end
			nxt_cnt = 2'd0;
			nxt_len = 3'd0;
		end
		if (raw.end_of_text) begin
			// Flush whatever is still held; nothing else was released then
			if (nxt_cnt != 2'd0) begin
				job.bytes[0] = nxt_held[0];
				job.bytes[1] = nxt_held[1];
				job.bytes[2] = nxt_held[2];
				job.cnt      = vudf_pkg::JobCntW'(nxt_cnt);
			end
			nxt_cnt = 2'd0;
			nxt_len = 3'd0;
		end
		job.eot = raw.end_of_text;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q <= 2'd0;
			exp_len_q  <= 3'd0;
		end else if (accept) begin
			held_cnt_q <= nxt_cnt;
			exp_len_q  <= nxt_len;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			held_q <= nxt_held;
	end

endmodule

@@ hdl/vudf_queue.sv @@
// ----------------------------------------------------------------------------
// vudf_queue
// Short job queue decoupling the classifier from the byte serialiser.
// ----------------------------------------------------------------------------
module vudf_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  vudf_pkg::vudf_job_t push_job,
	output logic                full,
	input  logic                pop,
	output logic                empty,
	output vudf_pkg::vudf_job_t head
);

	vudf_pkg::vudf_job_t          mem_q [vudf_pkg::QDepth];
	logic [vudf_pkg::QPtrW-1:0]   wr_ptr_q;
	logic [vudf_pkg::QPtrW-1:0]   rd_ptr_q;
	logic [vudf_pkg::QCntW-1:0]   cnt_q;
	logic                         do_push;
	logic                         do_pop;

	assign full    = cnt_q == vudf_pkg::QCntW'(vudf_pkg::QDepth);
	assign empty   = cnt_q == '0;
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_job;
	end

endmodule

@@ hdl/vudf_back.sv @@
// ----------------------------------------------------------------------------
// vudf_back
// Serialise queued jobs into the output register, one byte per transfer.
// ----------------------------------------------------------------------------
module vudf_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                empty,
	input  vudf_pkg::vudf_job_t head,
	output logic                pop,
	vudf_out_if.source          folded
);

	logic [vudf_pkg::JobIdxW-1:0] idx_q;
	logic                         out_valid_q;
	logic [7:0]                   out_byte_q;
	logic                         run_last_q;
	logic                         text_done_q;
	logic                         load;
	logic                         last;

	assign load = !empty && (!out_valid_q || folded.ready);
	assign last = vudf_pkg::JobCntW'(idx_q) == head.cnt - vudf_pkg::JobCntW'(1);
	assign pop  = load && last;

	assign folded.valid     = out_valid_q;
	assign folded.out_byte  = out_byte_q;
	assign folded.run_last  = run_last_q;
	assign folded.text_done = text_done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= last ? '0 : idx_q + 1'b1;
		end else if (folded.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q  <= head.bytes[idx_q];
			run_last_q  <= last;
			text_done_q <= last && head.eot;
		end
	end

endmodule

@@ hdl/vietnamese_utf8_diacritic_fold_top.sv @@
// ----------------------------------------------------------------------------
// vietnamese_utf8_diacritic_fold_top
// Fold Vietnamese UTF-8 text for search: strip diacritics from precomposed
// vowels, map the two d letters to 'd' and lower-case ASCII capitals.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Payload                            Transfer when
//  -------  ------  ---------------------------------  ---------------
//  raw      sink    in_byte[7:0], end_of_text          valid && ready
//  folded   source  out_byte[7:0], run_last, text_done valid && ready
//
//  Cycles: one raw byte per cycle while the queue has room; its first folded
//  byte goes through the job queue, then the output register, which gives
//  one byte per cycle while ready; a releasing byte gives up to four bytes.
//  Stalls: raw.ready drops only while the four-job queue is full.
//  Reset: arst_n clears the held sequence, the queue and the output register.
//
module vietnamese_utf8_diacritic_fold_top (
	input  logic       clk,
	input  logic       arst_n,
	vudf_in_if.sink    raw,
	vudf_out_if.source folded
);

	vudf_pkg::vudf_job_t new_job;
	vudf_pkg::vudf_job_t head_job;
	logic                push;
	logic                pop;
	logic                q_full;
	logic                q_empty;

	// Front: classify each raw byte, hold partial sequences, build its job
	vudf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw),
		.q_full (q_full),
		.push   (push),
		.job    (new_job)
	);

	// Queue: absorb bursts when one byte releases several
	vudf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (new_job),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head_job)
	);

	// Back: drain each job byte by byte through the output register
	vudf_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (q_empty),
		.head   (head_job),
		.pop    (pop),
		.folded (folded)
	);

endmodule

@@ hdl/vudf_checker.sv @@
// ----------------------------------------------------------------------------
// vudf_checker
// Port-level checks on the fold block, bound to the top level.
// ----------------------------------------------------------------------------
module vudf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       run_last,
	input logic       text_done
);

	// A stalled result holds its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) &&
		$stable(run_last) && $stable(text_done))
		else $error("folded result changed while stalled");

	// The end of a text always closes a run
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && text_done |-> run_last)
		else $error("text_done without run_last");

	// Nothing is offered straight out of reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !out_valid)
		else $error("result offered on leaving reset");

endmodule

bind vietnamese_utf8_diacritic_fold_top vudf_checker u_vudf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (folded.valid),
	.out_ready (folded.ready),
	.out_byte  (folded.out_byte),
	.run_last  (folded.run_last),
	.text_done (folded.text_done)
);

@@ tb/vietnamese_utf8_diacritic_fold_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vietnamese_utf8_diacritic_fold_top_test
// Self-checking bench for the Vietnamese UTF-8 diacritic fold. A directed
// table covers the edge bytes, the fold targets and the end-of-text flush.
// Random text then mixes well-formed characters with stray and broken
// sequences. Every folded byte is compared with a software fold of the
// accepted raw bytes, under several patterns of sender idling and receiver
// stalling.
// ----------------------------------------------------------------------------
module vietnamese_utf8_diacritic_fold_top_test;

	// Generous bound: roughly 330 bytes, up to four results each, long stalls
	localparam int unsigned CycleLimit = 400000;
	localparam int unsigned RandPerPhase = 76;
	localparam int unsigned DrainCycles = 16;

	// One raw byte of stimulus. Rows with typed set carry their folded
	// bytes in text_x, first byte in the top lane; other rows rely on the
	// software fold.
	typedef struct packed {
		logic [7:0]  text_b;
		logic        text_eot;
		logic        typed;
		logic [2:0]  text_n;
		logic [31:0] text_x;
	} text_row_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       text_done;
	} folded_t;

	logic clk;
	logic arst_n;

	vudf_in_if  raw_ch ();
	vudf_out_if folded_ch ();

	vietnamese_utf8_diacritic_fold_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.raw    (raw_ch),
		.folded (folded_ch)
	);

	// Directed text: edge bytes, several fold target families, a code point just
	// below the three-byte range, a four-byte pass-through, a broken
	// sequence and flushes at end of text.
	text_row_t dir_tab [0:25] = '{
		'{8'h41, 1'b0, 1'b1, 3'd1, 32'h6100_0000},  // capital A
		'{8'h5A, 1'b0, 1'b1, 3'd1, 32'h7A00_0000},  // capital Z
		'{8'h7F, 1'b0, 1'b1, 3'd1, 32'h7F00_0000},  // top of ASCII
		'{8'h80, 1'b0, 1'b1, 3'd1, 32'h8000_0000},  // stray continuation
		'{8'hFF, 1'b0, 1'b1, 3'd1, 32'hFF00_0000},  // invalid lead
		'{8'hC3, 1'b0, 1'b1, 3'd0, 32'h0000_0000},  // two-byte lead, held
		'{8'h80, 1'b0, 1'b1, 3'd1, 32'h6100_0000},  // U+00C0 folds to a
		'{8'hC4, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
		'{8'h91, 1'b0, 1'b1, 3'd1, 32'h6400_0000},  // U+0111 folds to d
		'{8'hE1, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
		'{8'hBB, 1'b0, 1'b1, 3'd0, 32'h0000_0000},
		'{8'hB9, 1'b0, 1'b1, 3'd1, 32'h7900_0000},  // U+1EF9 folds to y
		'{8'hC4, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'hA8, 1'b0, 1'b0, 3'd0, 32'h0000_0000},  // U+0128
		'{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'hBA, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'h9F, 1'b0, 1'b0, 3'd0, 32'h0000_0000},  // U+1E9F, just outside
		'{8'hF0, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'h9F, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'h98, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'h80, 1'b0, 1'b0, 3'd0, 32'h0000_0000},  // four bytes out at once
		'{8'hC3, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'h41, 1'b0, 1'b0, 3'd0, 32'h0000_0000},  // lead then non-continuation
		'{8'hE1, 1'b0, 1'b0, 3'd0, 32'h0000_0000},
		'{8'hBB, 1'b1, 1'b1, 3'd2, 32'hE1BB_0000},  // end of text flushes the hold
		'{8'h00, 1'b1, 1'b1, 3'd1, 32'h0000_0000}   // zero byte closing a string
	};

	int idle_tab  [4] = '{0, 81, 0, 14};
	int stall_tab [4] = '{0, 0, 81, 14};

	text_row_t  text_q [$];
	folded_t    fold_q [$];
	logic [7:0] step_bytes [$];
	text_row_t  cur_row;

	// Software copy of the fold state
	logic [7:0]  pend_bytes [3];
	int unsigned pend_cnt;
	int unsigned pend_len;

	int          idle_pct;
	int          stall_pct;
	int unsigned err_cnt;
	int unsigned cycle_cnt;

	// ------------------------------------------------------------------------
	// Software fold
	// ------------------------------------------------------------------------

	function automatic logic is_trail(input logic [7:0] b);
		return b[7:6] == 2'b10;
	endfunction

	// Plain letter for an exact two-byte code point, zero when none
	function automatic logic [7:0] base_of_two(input logic [10:0] cp);
		logic [10:0] up;
		up = (cp >= 11'h0E0 && cp <= 11'h0FF) ? cp - 11'h020 : cp;
		if (up >= 11'h0C0 && up <= 11'h0C3) return "a";
		if (up >= 11'h0C8 && up <= 11'h0CA) return "e";
		if (up >= 11'h0CC && up <= 11'h0CD) return "i";
		if (up >= 11'h0D2 && up <= 11'h0D5) return "o";
		if (up >= 11'h0D9 && up <= 11'h0DA) return "u";
		if (up == 11'h0DD) return "y";
		case (cp)
			11'h102, 11'h103: return "a";
			11'h128, 11'h129: return "i";
			11'h168, 11'h169: return "u";
			11'h1A0, 11'h1A1: return "o";
			11'h1AF, 11'h1B0: return "u";
			11'h110, 11'h111: return "d";
			default: return 8'h00;
		endcase
	endfunction

	// Plain letter for a three-byte code point in the extended Latin block
	function automatic logic [7:0] base_of_three(input logic [15:0] cp);
		if (cp < 16'h1EA0 || cp > 16'h1EF9) return 8'h00;
		if (cp <= 16'h1EB7) return "a";
		if (cp <= 16'h1EC7) return "e";
		if (cp <= 16'h1ECB) return "i";
		if (cp <= 16'h1EE3) return "o";
		if (cp <= 16'h1EF1) return "u";
		return "y";
	endfunction

	// Fold one raw byte into step_bytes and advance the held sequence
	task automatic fold_step(input logic [7:0] c, input logic eot);
		logic [7:0] letter;
		step_bytes.delete();
		letter = 8'h00;
		if (pend_cnt == 0) begin
			if (c < 8'h80) begin
				step_bytes.push_back((c >= "A" && c <= "Z") ? c + 8'd32 : c);
			end else if (c[7:5] == 3'b110 || c[7:4] == 4'b1110 || c[7:3] == 5'b11110) begin
				pend_len = (c[7:5] == 3'b110) ? 2 : (c[7:4] == 4'b1110) ? 3 : 4;
				pend_bytes[0] = c;
				pend_cnt = 1;
			end else begin
				step_bytes.push_back(c);
			end
		end else if (pend_cnt + 1 < pend_len) begin
			pend_bytes[pend_cnt] = c;
			pend_cnt++;
		end else begin
			if (pend_len == 2 && is_trail(c))
				letter = base_of_two({pend_bytes[0][4:0], c[5:0]});
			else if (pend_len == 3 && is_trail(pend_bytes[1]) && is_trail(c) &&
					pend_bytes[0] == 8'hE1)
				letter = base_of_three({4'h1, pend_bytes[1][5:0], c[5:0]});
			if (letter != 8'h00) begin
				step_bytes.push_back(letter);
			end else begin
				for (int i = 0; i < pend_cnt; i++)
					step_bytes.push_back(pend_bytes[i]);
				step_bytes.push_back(c);
			end
			pend_cnt = 0;
			pend_len = 0;
		end
		// Flush whatever is still held at end of text
		if (eot) begin
			for (int i = 0; i < pend_cnt; i++)
				step_bytes.push_back(pend_bytes[i]);
			pend_cnt = 0;
			pend_len = 0;
		end
	endtask

	// ------------------------------------------------------------------------
	// Random text
	// ------------------------------------------------------------------------

	// Queue one raw byte; about one in sixteen closes a string
	task automatic push_byte(input logic [7:0] b);
		text_row_t r;
		r = '0;
		r.text_b = b;
		r.text_eot = ($urandom_range(15) == 0);
		text_q.push_back(r);
	endtask

	task automatic push_trail();
		push_byte({2'b10, 6'($urandom_range(63))});
	endtask

	// Queue one character: mostly well-formed, some stray or broken bytes
	task automatic push_char();
		int          pick;
		int          tail;
		logic [10:0] cp2;
		logic [11:0] cp3;
		pick = $urandom_range(99);
		if (pick < 12) begin
			push_byte(8'($urandom_range(8'h41, 8'h5A)));
		end else if (pick < 25) begin
			push_byte(8'($urandom_range(8'h7F)));
		end else if (pick < 45) begin
			// Two-byte letters around the Latin-1 and Latin Extended vowels
			cp2 = 11'($urandom_range(11'h0C0, 11'h1BF));
			push_byte({3'b110, cp2[10:6]});
			push_byte({2'b10, cp2[5:0]});
		end else if (pick < 65) begin
			// Three-byte letters around the Vietnamese block under lead E1
			cp3 = 12'($urandom_range(12'hE80, 12'hEFF));
			push_byte(8'hE1);
			push_byte({2'b10, cp3[11:6]});
			push_byte({2'b10, cp3[5:0]});
		end else if (pick < 73) begin
			push_byte({4'b1110, 4'($urandom_range(15))});
			push_trail();
			push_trail();
		end else if (pick < 81) begin
			push_byte({5'b11110, 3'($urandom_range(7))});
			push_trail();
			push_trail();
			push_trail();
		end else if (pick < 88) begin
			if ($urandom_range(1) == 0)
				push_byte(8'($urandom_range(8'h80, 8'hBF)));
			else
				push_byte(8'($urandom_range(8'hF8, 8'hFF)));
		end else begin
			// Broken sequence: a lead followed by a few bytes of any value
			push_byte(8'($urandom_range(8'hC0, 8'hF7)));
			tail = $urandom_range(2);
			for (int i = 0; i < tail; i++)
				push_byte(8'($urandom_range(255)));
		end
	endtask

	// ------------------------------------------------------------------------
	// Clock, receiver and cycle limit
	// ------------------------------------------------------------------------

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Stall the folded channel at the rate the current phase asks
	always @(negedge clk)
		folded_ch.ready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt >= CycleLimit) begin
			$display("** vietnamese_utf8_diacritic_fold_top: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Scoreboard: check folded transfers, then predict from raw transfers
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		folded_t got;
		folded_t want;
		int      last;
		if (arst_n) begin
			if (folded_ch.valid && folded_ch.ready) begin
				got = '{folded_ch.out_byte, folded_ch.run_last, folded_ch.text_done};
				if (fold_q.size() == 0) begin
					$error("folded transfer %02h with nothing expected", got.out_byte);
					err_cnt++;
				end else begin
					want = fold_q.pop_front();
					if (got.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, got %02h", want.out_byte, got.out_byte);
						err_cnt++;
					end
					if (got.run_last !== want.run_last) begin
						$error("run_last: expected %0b, got %0b", want.run_last, got.run_last);
						err_cnt++;
					end
					if (got.text_done !== want.text_done) begin
						$error("text_done: expected %0b, got %0b", want.text_done,
							got.text_done);
						err_cnt++;
					end
				end
			end
			if (raw_ch.valid && raw_ch.ready) begin
				fold_step(raw_ch.in_byte, raw_ch.end_of_text);
				// Typed rows override the software fold, which still advances
				if (cur_row.typed) begin
					step_bytes.delete();
					for (int i = 0; i < cur_row.text_n; i++)
						step_bytes.push_back(cur_row.text_x[31 - 8 * i -: 8]);
				end
				last = step_bytes.size() - 1;
				foreach (step_bytes[i]) begin
					want.out_byte  = step_bytes[i];
					want.run_last  = (i == last);
					want.text_done = raw_ch.end_of_text && (i == last);
					fold_q.push_back(want);
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// Sender
	// ------------------------------------------------------------------------

	// Call at a falling edge; return at the falling edge after the transfer
	task automatic send_row(input text_row_t r);
		while ($urandom_range(99) < idle_pct) begin
			raw_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cur_row = r;
		raw_ch.valid       <= 1'b1;
		raw_ch.in_byte     <= r.text_b;
		raw_ch.end_of_text <= r.text_eot;
		do @(posedge clk); while (!raw_ch.ready);
		@(negedge clk);
	endtask

	initial begin
		int n0;
		int half;
		arst_n = 1'b0;
		raw_ch.valid = 1'b0;
		raw_ch.in_byte = 8'h00;
		raw_ch.end_of_text = 1'b0;
		folded_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		err_cnt = 0;
		cycle_cnt = 0;
		pend_cnt = 0;
		pend_len = 0;
		cur_row = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = idle_tab[ph];
			stall_pct = stall_tab[ph];
			text_q.delete();
			if (ph == 0)
				foreach (dir_tab[i]) text_q.push_back(dir_tab[i]);
			n0 = text_q.size();
			while (text_q.size() < n0 + RandPerPhase)
				push_char();
			half = text_q.size() / 2;
			foreach (text_q[k]) begin
				// Hold off mid-phase until every folded byte has drained
				if (ph == 2 && k == half) begin
					raw_ch.valid <= 1'b0;
					do @(negedge clk); while (fold_q.size() != 0);
				end
				send_row(text_q[k]);
			end
		end
		raw_ch.valid <= 1'b0;

		while (fold_q.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (err_cnt == 0)
			$display("** vietnamese_utf8_diacritic_fold_top: PASSED **");
		else
			$display("** vietnamese_utf8_diacritic_fold_top: FAILED **");
		$finish;
	end

endmodule
